// ===== rtl/core/ltoc_pkg.sv =====
// Shared types and constants for the toroidal Life oscillator checker.
// Used by the controller, the datapath and the top level; depends on nothing.
package ltoc_pkg;

    // Board geometry. The row count is fixed; the maximum column count is a top-level parameter.
    localparam int LTOC_ROWS          = 3;
    localparam int LTOC_MAX_COLS      = 10;

    // Generation counter and limit register.
    localparam int          LTOC_GEN_W         = 7;
    localparam logic [6:0]  LTOC_MAX_GEN_RESET = 7'd100;

    // Result transaction layout: is_oscillator, generations, outcome, zero fill.
    localparam int LTOC_OUTCOME_W   = 2;
    localparam int LTOC_OUT_TDATA_W = 16;

    // Outcome codes reported with every result.
    typedef enum logic [LTOC_OUTCOME_W-1:0] {
        OUTCOME_RETURNED = 2'd0,
        OUTCOME_STILL    = 2'd1,
        OUTCOME_SETTLED  = 2'd2,
        OUTCOME_LIMIT    = 2'd3
    } ltoc_outcome_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } ltoc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ltoc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic back_to_start;
    } ltoc_status_t;

endpackage

// ===== rtl/core/life_torus_oscillator_check_top.sv =====
// Top level of the toroidal Life oscillator checker.
// Depends on ltoc_pkg, ltoc_ctrl and ltoc_datapath.
//
//  Channel   Dir  Contents
//  s_axis    in   start_board, board_width
//  m_axis    out  is_oscillator, generations, outcome
//  cfg_wr    in   max_generations
//
// A board is loaded, then advanced one generation per step until it returns to its start,
// settles or reaches max_generations, and then its result is handed out.
// All cells of a generation are updated in parallel.
// Reset is synchronous and active low; the limit returns to 100.
// A result waits in the output register while the next board is taken; a run
// holds at its end only while the previous result is still unread.
module life_torus_oscillator_check_top #(
    parameter int MAX_COLS = ltoc_pkg::LTOC_MAX_COLS
) (
    input  logic aclk,
    input  logic aresetn,

    // Limit register write.
    input  logic                            cfg_wr_en,
    input  logic [ltoc_pkg::LTOC_GEN_W-1:0] cfg_wr_data,

    // Start boards.
    input  logic                                                     s_axis_tvalid,
    output logic                                                     s_axis_tready,
    // start_board, board_width, zero fill
    input  logic [((ltoc_pkg::LTOC_ROWS*MAX_COLS+$clog2(MAX_COLS+1)+7)/8)*8-1:0]
                                                                     s_axis_tdata,

    // Results.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // is_oscillator, generations, outcome, zero fill
    output logic [ltoc_pkg::LTOC_OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int BOARD_W = ltoc_pkg::LTOC_ROWS * MAX_COLS;
    localparam int WB      = $clog2(MAX_COLS + 1);

    ltoc_pkg::ltoc_cmd_t    cmd;
    ltoc_pkg::ltoc_status_t sts;

    ltoc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ltoc_datapath #(
        .MAX_COLS (MAX_COLS),
        .BOARD_W  (BOARD_W),
        .WB       (WB)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start_board (s_axis_tdata[BOARD_W-1:0]),
        .board_width (s_axis_tdata[BOARD_W +: WB]),
        .cmd         (cmd),
        .sts         (sts),
        .result_data (m_axis_tdata)
    );

`ifndef SYNTH
    // The oscillator flag agrees with the outcome code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[0] ==
            (m_axis_tdata[9:8] == ltoc_pkg::OUTCOME_RETURNED)))
        else $error("oscillator flag disagrees with outcome");

    // A still life is found after exactly one generation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[9:8] == ltoc_pkg::OUTCOME_STILL))
            |-> (m_axis_tdata[7:1] == 7'd1))
        else $error("still life reported with wrong generation count");

    // An accepted board starts a run, so no second board is taken next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("board accepted while a run is in progress");

    // Returning to the start always ends the run at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.back_to_start |-> sts.done)
        else $error("run continues after returning to start");
`endif

endmodule

// ===== rtl/core/ltoc_ctrl.sv =====
// Controller state machine for the Life oscillator checker.
// Depends on ltoc_pkg; drives the datapath commands and the result valid flag.
module ltoc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  ltoc_pkg::ltoc_status_t sts,
    output ltoc_pkg::ltoc_cmd_t    cmd
);

    ltoc_pkg::ltoc_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // State and result valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ltoc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ltoc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ltoc_pkg::ST_RUN;
                end
            end
            ltoc_pkg::ST_RUN: begin
                if (!sts.done) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ltoc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ltoc_pkg::ST_IDLE;
            end
        endcase
    end

    // A result stays valid until the downstream side takes it.
    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== rtl/core/ltoc_datapath.sv =====
// Datapath of the Life oscillator checker: board registers, one-generation
// cell update, stop detection, limit register and result register. Depends on ltoc_pkg.
module ltoc_datapath #(
    parameter int MAX_COLS = ltoc_pkg::LTOC_MAX_COLS,
    parameter int BOARD_W  = ltoc_pkg::LTOC_ROWS * MAX_COLS,
    parameter int WB       = $clog2(MAX_COLS + 1)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ltoc_pkg::LTOC_GEN_W-1:0]       cfg_wr_data,
    input  logic [BOARD_W-1:0]                    start_board,
    input  logic [WB-1:0]                         board_width,
    input  ltoc_pkg::ltoc_cmd_t                   cmd,
    output ltoc_pkg::ltoc_status_t                sts,
    output logic [ltoc_pkg::LTOC_OUT_TDATA_W-1:0] result_data
);

    localparam int CIW = $clog2(MAX_COLS);

    logic [BOARD_W-1:0]                board_reg, board_next;
    logic [BOARD_W-1:0]                start_reg, start_next;
    logic [WB-1:0]                     width_reg, width_next;
    logic [ltoc_pkg::LTOC_GEN_W-1:0]   gen_reg, gen_next;
    logic                              back_reg, back_next;
    logic                              settled_reg, settled_next;
    logic [ltoc_pkg::LTOC_GEN_W-1:0]   max_gen_reg;
    logic                              osc_reg, osc_next;
    logic [ltoc_pkg::LTOC_GEN_W-1:0]   res_gen_reg, res_gen_next;
    ltoc_pkg::ltoc_outcome_t           outcome_reg, outcome_next;

    logic [WB-1:0]                     width_clamped;
    logic [BOARD_W-1:0]                start_masked;
    logic [BOARD_W-1:0]                gen_board;
    logic [CIW-1:0]                    w_m1;
    logic [MAX_COLS-1:0]               row_bits [ltoc_pkg::LTOC_ROWS];

    // Clamp the column count into the supported range.
    always_comb begin
        if (board_width < WB'(2)) begin
            width_clamped = WB'(2);
        end else if (board_width > WB'(MAX_COLS)) begin
            width_clamped = WB'(MAX_COLS);
        end else begin
            width_clamped = board_width;
        end
    end

    assign w_m1 = CIW'(width_reg - WB'(1));

    // Start mask, row slices and the parallel cell update of one generation.
    genvar r, c;
    generate
        for (r = 0; r < ltoc_pkg::LTOC_ROWS; r++) begin : g_row
            localparam int UP = (r + ltoc_pkg::LTOC_ROWS - 1) % ltoc_pkg::LTOC_ROWS;
            localparam int DN = (r + 1) % ltoc_pkg::LTOC_ROWS;

            assign row_bits[r] = board_reg[r*MAX_COLS +: MAX_COLS];

            for (c = 0; c < MAX_COLS; c++) begin : g_col
                logic [CIW-1:0] lf;
                logic [CIW-1:0] rt;
                logic [3:0]     cnt;

                assign start_masked[r*MAX_COLS+c] =
                    start_board[r*MAX_COLS+c] && (WB'(c) < width_clamped);

                // Left neighbor wraps from the first column to the last one in use.
                if (c == 0) begin : g_lf_wrap
                    assign lf = w_m1;
                end else begin : g_lf_plain
                    assign lf = CIW'(c - 1);
                end

                // Right neighbor wraps from the last column in use to the first.
                assign rt = (WB'(c + 1) == width_reg) ? '0 : CIW'(c + 1);

                assign cnt = 4'(row_bits[UP][lf]) + 4'(row_bits[r][lf])
                           + 4'(row_bits[DN][lf]) + 4'(row_bits[UP][c])
                           + 4'(row_bits[DN][c])  + 4'(row_bits[UP][rt])
                           + 4'(row_bits[r][rt])  + 4'(row_bits[DN][rt]);

                // Birth on three neighbors, survival on two or three.
                assign gen_board[r*MAX_COLS+c] = (WB'(c) < width_reg)
                    && ((cnt == 4'd3) || (row_bits[r][c] && (cnt == 4'd2)));
            end
        end
    endgenerate

    // Stop conditions seen by the controller.
    assign sts.back_to_start = back_reg;
    assign sts.done          = back_reg || settled_reg || (gen_reg >= max_gen_reg);

    // Board, flags and generation counter.
    always_comb begin
        board_next   = board_reg;
        start_next   = start_reg;
        width_next   = width_reg;
        gen_next     = gen_reg;
        back_next    = back_reg;
        settled_next = settled_reg;
        if (cmd.load) begin
            board_next   = start_masked;
            start_next   = start_masked;
            width_next   = width_clamped;
            gen_next     = '0;
            back_next    = 1'b0;
            settled_next = 1'b0;
        end else if (cmd.step) begin
            board_next   = gen_board;
            gen_next     = gen_reg + 1'b1;
            back_next    = (gen_board == start_reg);
            settled_next = (gen_board == board_reg);
        end
    end

    // Result fields, captured when the controller hands the result out.
    always_comb begin
        osc_next     = osc_reg;
        res_gen_next = res_gen_reg;
        outcome_next = outcome_reg;
        if (cmd.emit) begin
            res_gen_next = gen_reg;
            osc_next     = back_reg && (gen_reg > 7'd1);
            if (back_reg) begin
                outcome_next = (gen_reg > 7'd1) ? ltoc_pkg::OUTCOME_RETURNED
                                                : ltoc_pkg::OUTCOME_STILL;
            end else if (settled_reg) begin
                outcome_next = ltoc_pkg::OUTCOME_SETTLED;
            end else begin
                outcome_next = ltoc_pkg::OUTCOME_LIMIT;
            end
        end
    end

    // Payload registers, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_reg   <= '0;
            start_reg   <= '0;
            width_reg   <= '0;
            gen_reg     <= '0;
            back_reg    <= 1'b0;
            settled_reg <= 1'b0;
            osc_reg     <= 1'b0;
            res_gen_reg <= '0;
            outcome_reg <= ltoc_pkg::OUTCOME_RETURNED;
        end else begin
            board_reg   <= board_next;
            start_reg   <= start_next;
            width_reg   <= width_next;
            gen_reg     <= gen_next;
            back_reg    <= back_next;
            settled_reg <= settled_next;
            osc_reg     <= osc_next;
            res_gen_reg <= res_gen_next;
            outcome_reg <= outcome_next;
        end
    end

    // Generation limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gen_reg <= ltoc_pkg::LTOC_MAX_GEN_RESET;
        end else if (cfg_wr_en) begin
            max_gen_reg <= cfg_wr_data;
        end
    end

    assign result_data = {
        (ltoc_pkg::LTOC_OUT_TDATA_W - 1 - ltoc_pkg::LTOC_GEN_W - ltoc_pkg::LTOC_OUTCOME_W)'(0),
        outcome_reg, res_gen_reg, osc_reg
    };

endmodule
